// ===== hdl/line_halfplane_clipper_core_defines.svh =====
// Assertion macros for the half-plane clipper core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LINE_HALFPLANE_CLIPPER_CORE_DEFINES_SVH
`define LINE_HALFPLANE_CLIPPER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LHC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define LHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/lhc_pkg.sv =====
// Shared types, codes and helpers of the half-plane clipper core.
// No dependencies; imported by lhc_arith and line_halfplane_clipper_core.
`default_nettype none
package lhc_pkg;

  localparam int LHC_MAX_ROWS = 16;
  localparam int LHC_ROW_AW   = 4;
  localparam int LHC_W        = 130;

  typedef logic signed [LHC_W-1:0] lhc_word_t;

  // operation field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CLIP = 1'b1;

  // result status
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_DEGEN = 2'd2;

  // register indexes
  localparam logic CFG_TOLERANCE   = 1'b0;
  localparam logic CFG_PARAM_LIMIT = 1'b1;

  localparam logic [15:0] TOL_RESET  = 16'd7;
  localparam logic [46:0] PLIM_RESET = 47'd65536000000;

  // arithmetic unit operations
  localparam logic [1:0] UOP_ADD = 2'd0;
  localparam logic [1:0] UOP_SUB = 2'd1;
  localparam logic [1:0] UOP_MUL = 2'd2;
  localparam logic [1:0] UOP_DIV = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } lhc_cmd_t;

  localparam logic signed [47:0] SAT_HI = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SAT_LO = {1'b1, {47{1'b0}}};
  localparam lhc_word_t FRAC_ONE = 65536;

  function automatic logic signed [47:0] lhc_sat48(input lhc_word_t v);
    if (v > lhc_word_t'(SAT_HI)) return SAT_HI;
    else if (v < lhc_word_t'(SAT_LO)) return SAT_LO;
    else return v[47:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/line_halfplane_clipper_core.sv =====
// Load: loads are taken back to back while the core is idle; in_stall holds them off
// during a clip. Clip: setup, then each walked row in turn, then the endpoints, all
// through the bit-serial multiply and the 130-step restoring divide of lhc_arith.
// Reset clears control state and the two registers; the row table is undefined
// until loaded. Uses lhc_pkg, lhc_ram, lhc_arith and the assertion macro header.
`default_nettype none
`include "line_halfplane_clipper_core_defines.svh"
module line_halfplane_clipper_core
  import lhc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [46:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               operation,
  input  wire logic [3:0]         row_index,
  input  wire logic signed [31:0] coef_x,
  input  wire logic signed [31:0] coef_y,
  input  wire logic signed [31:0] bound,
  input  wire logic [4:0]         row_count,
  input  wire logic [3:0]         line_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic signed [47:0]      start_x,
  output logic signed [47:0]      start_y,
  output logic signed [47:0]      end_x,
  output logic signed [47:0]      end_y
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_LLATCH = 5'd1;
  localparam logic [4:0] ST_N1     = 5'd2;
  localparam logic [4:0] ST_N2     = 5'd3;
  localparam logic [4:0] ST_N3     = 5'd4;
  localparam logic [4:0] ST_ROW    = 5'd5;
  localparam logic [4:0] ST_RLATCH = 5'd6;
  localparam logic [4:0] ST_F1     = 5'd7;
  localparam logic [4:0] ST_F2     = 5'd8;
  localparam logic [4:0] ST_F3     = 5'd9;
  localparam logic [4:0] ST_P1     = 5'd10;
  localparam logic [4:0] ST_P2     = 5'd11;
  localparam logic [4:0] ST_P3     = 5'd12;
  localparam logic [4:0] ST_PC     = 5'd13;
  localparam logic [4:0] ST_Q1     = 5'd14;
  localparam logic [4:0] ST_Q2     = 5'd15;
  localparam logic [4:0] ST_Q3     = 5'd16;
  localparam logic [4:0] ST_T1     = 5'd17;
  localparam logic [4:0] ST_T2     = 5'd18;
  localparam logic [4:0] ST_T3     = 5'd19;
  localparam logic [4:0] ST_T4     = 5'd20;
  localparam logic [4:0] ST_FIN    = 5'd21;
  localparam logic [4:0] ST_B1     = 5'd22;
  localparam logic [4:0] ST_B2     = 5'd23;
  localparam logic [4:0] ST_B3     = 5'd24;
  localparam logic [4:0] ST_B4     = 5'd25;
  localparam logic [4:0] ST_C1     = 5'd26;
  localparam logic [4:0] ST_C2     = 5'd27;
  localparam logic [4:0] ST_C3     = 5'd28;
  localparam logic [4:0] ST_EMIT   = 5'd29;

  logic [4:0]  state;
  logic [15:0] tol;
  logic [46:0] plim;

  logic [3:0]  line;
  logic [4:0]  cnt, i;
  logic        empty;
  logic [1:0]  k;
  logic [1:0]  res_status;

  logic signed [31:0] A, B, C, Ai, Bi, Ci;
  logic        [63:0] N;
  logic signed [65:0] F, P;
  logic signed [97:0] PC;
  logic signed [49:0] BX, BY;
  logic signed [47:0] tmin, tmax;
  lhc_word_t          X, Y;
  logic signed [47:0] coord [4];

  // row table
  logic                  ram_we;
  logic [LHC_ROW_AW-1:0] ram_raddr;
  logic [95:0]           ram_rdata;

  assign in_stall  = (state != ST_IDLE);
  assign ram_we    = in_valid && !in_stall && (operation == OP_LOAD);
  assign ram_raddr = (state == ST_IDLE) ? line_index : i[LHC_ROW_AW-1:0];

  lhc_ram #(.WIDTH(96), .DEPTH(LHC_MAX_ROWS)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_index),
    .wdata ({coef_x, coef_y, bound}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared arithmetic unit
  lhc_cmd_t  u_cmd;
  lhc_word_t u_a, u_b, u_res;
  logic      u_done, u_need, issued;
  logic [1:0] u_op;

  lhc_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (u_cmd),
    .a      (u_a),
    .b      (u_b),
    .done   (u_done),
    .result (u_res)
  );

  logic signed [32:0] neg_a;
  logic signed [47:0] t_sel, t_sat;
  logic signed [32:0] d_sel;
  logic signed [49:0] b_sel;
  logic signed [65:0] par_lim;
  logic               par;
  logic signed [48:0] tmin_tol;

  assign neg_a    = -33'(A);
  assign t_sel    = k[1] ? tmax : tmin;
  assign d_sel    = k[0] ? neg_a : 33'(B);
  assign b_sel    = k[0] ? BY : BX;
  assign t_sat    = lhc_sat48(u_res);
  assign par_lim  = $signed({34'b0, tol, 16'b0});
  assign par      = (F == '0) || ((F < par_lim) && (F > -par_lim));
  assign tmin_tol = 49'(tmin) + $signed({33'b0, tol});

  always_comb begin
    u_a    = '0;
    u_b    = '0;
    u_op   = UOP_ADD;
    u_need = 1'b1;
    case (state)
      ST_N1: begin u_op = UOP_MUL; u_a = lhc_word_t'(A); u_b = lhc_word_t'(A); end
      ST_N2: begin u_op = UOP_MUL; u_a = lhc_word_t'(B); u_b = lhc_word_t'(B); end
      ST_N3: begin u_op = UOP_ADD; u_a = lhc_word_t'(N); u_b = X; end
      ST_F1: begin u_op = UOP_MUL; u_a = lhc_word_t'(Ai); u_b = lhc_word_t'(B); end
      ST_F2: begin u_op = UOP_MUL; u_a = lhc_word_t'(Bi); u_b = lhc_word_t'(A); end
      ST_F3: begin u_op = UOP_SUB; u_a = X; u_b = lhc_word_t'(F); end
      ST_P1: begin u_op = UOP_MUL; u_a = lhc_word_t'(Ai); u_b = lhc_word_t'(A); end
      ST_P2: begin u_op = UOP_MUL; u_a = lhc_word_t'(Bi); u_b = lhc_word_t'(B); end
      ST_P3: begin u_op = UOP_ADD; u_a = X; u_b = lhc_word_t'(P); end
      ST_PC: begin u_op = UOP_MUL; u_a = lhc_word_t'(P); u_b = lhc_word_t'(C); end
      ST_Q1: begin u_op = UOP_ADD; u_a = lhc_word_t'(Ci); u_b = lhc_word_t'(tol); end
      ST_Q2: begin u_op = UOP_MUL; u_a = X; u_b = lhc_word_t'(N); end
      ST_Q3: begin u_op = UOP_SUB; u_a = lhc_word_t'(PC); u_b = X; end
      ST_T1: begin u_op = UOP_MUL; u_a = lhc_word_t'(Ci); u_b = lhc_word_t'(N); end
      ST_T2: begin u_op = UOP_SUB; u_a = X; u_b = lhc_word_t'(PC); end
      ST_T3: begin u_op = UOP_MUL; u_a = lhc_word_t'(N); u_b = lhc_word_t'(F); end
      ST_T4: begin u_op = UOP_DIV; u_a = X <<< 32; u_b = Y; end
      ST_B1: begin u_op = UOP_MUL; u_a = lhc_word_t'(A); u_b = lhc_word_t'(C); end
      ST_B2: begin u_op = UOP_DIV; u_a = X <<< 16; u_b = lhc_word_t'(N); end
      ST_B3: begin u_op = UOP_MUL; u_a = lhc_word_t'(B); u_b = lhc_word_t'(C); end
      ST_B4: begin u_op = UOP_DIV; u_a = X <<< 16; u_b = lhc_word_t'(N); end
      ST_C1: begin u_op = UOP_MUL; u_a = lhc_word_t'(t_sel); u_b = lhc_word_t'(d_sel); end
      // bias negatives so the shift below truncates toward zero
      ST_C2: begin
        u_op = UOP_ADD; u_a = X;
        u_b  = X[LHC_W-1] ? (FRAC_ONE - lhc_word_t'(1)) : '0;
      end
      ST_C3: begin u_op = UOP_ADD; u_a = X >>> 16; u_b = lhc_word_t'(b_sel); end
      default: u_need = 1'b0;
    endcase
  end

  assign u_cmd.start = u_need && !issued;
  assign u_cmd.op    = u_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      issued    <= 1'b0;
      tol       <= TOL_RESET;
      plim      <= PLIM_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOLERANCE:   tol  <= cfg_data[15:0];
          CFG_PARAM_LIMIT: plim <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != ST_EMIT) out_valid <= 1'b0;

      if (u_cmd.start) issued <= 1'b1;
      else if (u_done) issued <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid && operation == OP_CLIP) begin
            line  <= line_index;
            cnt   <= (row_count > 5'(LHC_MAX_ROWS)) ? 5'(LHC_MAX_ROWS) : row_count;
            state <= ST_LLATCH;
          end
        end
        ST_LLATCH: begin
          A          <= ram_rdata[95:64];
          B          <= ram_rdata[63:32];
          C          <= ram_rdata[31:0];
          res_status <= STATUS_OK;
          state      <= ST_N1;
        end
        ST_N1: if (u_done) begin N <= u_res[63:0]; state <= ST_N2; end
        ST_N2: if (u_done) begin X <= u_res; state <= ST_N3; end
        ST_N3: begin
          if (u_done) begin
            N <= u_res[63:0];
            if (u_res == '0) begin
              res_status <= STATUS_DEGEN;
              state      <= ST_EMIT;
            end else begin
              tmax  <= $signed({1'b0, plim});
              tmin  <= -$signed({1'b0, plim});
              i     <= '0;
              empty <= 1'b0;
              state <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          if (i >= cnt || empty) state <= ST_FIN;
          else if (i == {1'b0, line}) i <= i + 5'd1;   // skip the line's own row
          else state <= ST_RLATCH;
        end
        ST_RLATCH: begin
          Ai    <= ram_rdata[95:64];
          Bi    <= ram_rdata[63:32];
          Ci    <= ram_rdata[31:0];
          state <= ST_F1;
        end
        ST_F1: if (u_done) begin X <= u_res; state <= ST_F2; end
        ST_F2: if (u_done) begin F <= u_res[65:0]; state <= ST_F3; end
        ST_F3: if (u_done) begin F <= u_res[65:0]; state <= ST_P1; end
        ST_P1: if (u_done) begin X <= u_res; state <= ST_P2; end
        ST_P2: if (u_done) begin P <= u_res[65:0]; state <= ST_P3; end
        ST_P3: if (u_done) begin P <= u_res[65:0]; state <= ST_PC; end
        ST_PC: if (u_done) begin PC <= u_res[97:0]; state <= par ? ST_Q1 : ST_T1; end
        ST_Q1: if (u_done) begin X <= u_res; state <= ST_Q2; end
        ST_Q2: if (u_done) begin X <= u_res; state <= ST_Q3; end
        ST_Q3: begin
          if (u_done) begin
            // parallel row: P*C >= (Ci+tol)*N empties the segment
            if (!u_res[LHC_W-1]) empty <= 1'b1;
            i     <= i + 5'd1;
            state <= ST_ROW;
          end
        end
        ST_T1: if (u_done) begin X <= u_res; state <= ST_T2; end
        ST_T2: if (u_done) begin X <= u_res; state <= ST_T3; end
        ST_T3: if (u_done) begin Y <= u_res; state <= ST_T4; end
        ST_T4: begin
          if (u_done) begin
            if (!F[65]) begin
              if (t_sat < tmax) tmax <= t_sat;
            end else begin
              if (t_sat > tmin) tmin <= t_sat;
            end
            i     <= i + 5'd1;
            state <= ST_ROW;
          end
        end
        ST_FIN: begin
          if (empty || !(tmin_tol < 49'(tmax))) begin
            res_status <= STATUS_EMPTY;
            state      <= ST_EMIT;
          end else begin
            state <= ST_B1;
          end
        end
        ST_B1: if (u_done) begin X <= u_res; state <= ST_B2; end
        ST_B2: if (u_done) begin BX <= u_res[49:0]; state <= ST_B3; end
        ST_B3: if (u_done) begin X <= u_res; state <= ST_B4; end
        ST_B4: if (u_done) begin BY <= u_res[49:0]; k <= '0; state <= ST_C1; end
        ST_C1: if (u_done) begin X <= u_res; state <= ST_C2; end
        ST_C2: if (u_done) begin X <= u_res; state <= ST_C3; end
        ST_C3: begin
          if (u_done) begin
            coord[k] <= t_sat;
            k        <= k + 2'd1;
            state    <= (k == 2'd3) ? ST_EMIT : ST_C1;
          end
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            start_x   <= (res_status == STATUS_OK) ? coord[0] : '0;
            start_y   <= (res_status == STATUS_OK) ? coord[1] : '0;
            end_x     <= (res_status == STATUS_OK) ? coord[2] : '0;
            end_y     <= (res_status == STATUS_OK) ? coord[3] : '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic no_seg, ends_zero, clip_accept;

  assign no_seg      = out_valid && status != STATUS_OK;
  assign ends_zero   = start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0;
  assign clip_accept = in_valid && !in_stall && operation == OP_CLIP;

  `LHC_ASSERT_NEXT(a_unit_not_early, clk, rst, u_cmd.start, !u_done, "unit done right after start")
  `LHC_ASSERT_NOW(a_zero_when_no_segment, clk, rst, no_seg, ends_zero, "endpoints not zero")
  `LHC_ASSERT_NEXT(a_clip_starts, clk, rst, clip_accept, state == ST_LLATCH, "clip did not start")

endmodule
`default_nettype wire

// ===== hdl/lhc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/lhc_arith.sv =====
// Shared iterative arithmetic unit: add, subtract, shift-add multiply and
// restoring divide (truncating) on signed words, all through one adder. Uses lhc_pkg.
`default_nettype none
module lhc_arith
  import lhc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lhc_cmd_t  cmd,
  input  wire lhc_word_t a,
  input  wire lhc_word_t b,
  output logic           done,
  output lhc_word_t      result
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_ADD  = 3'd1;
  localparam logic [2:0] U_ABSA = 3'd2;
  localparam logic [2:0] U_ABSB = 3'd3;
  localparam logic [2:0] U_RUN  = 3'd4;
  localparam logic [2:0] U_FIX  = 3'd5;

  logic [2:0]       ust;
  logic [1:0]       uop;
  logic [LHC_W-1:0] x, y, r;
  logic             sgn;
  logic [7:0]       cnt;

  logic [LHC_W-1:0] ad_x, ad_y, rem_sh, fix_src;
  logic             ad_sub;
  logic [LHC_W:0]   ad_sum;

  assign rem_sh  = {r[LHC_W-2:0], x[LHC_W-1]};
  assign fix_src = (uop == UOP_DIV) ? x : r;

  always_comb begin
    ad_x   = x;
    ad_y   = y;
    ad_sub = 1'b0;
    case (ust)
      U_ADD: begin
        ad_sub = (uop == UOP_SUB);
      end
      U_ABSA: begin
        ad_x = '0; ad_y = x; ad_sub = 1'b1;
      end
      U_ABSB: begin
        ad_x = '0; ad_y = y; ad_sub = 1'b1;
      end
      U_RUN: begin
        if (uop == UOP_DIV) begin
          ad_x = rem_sh; ad_y = y; ad_sub = 1'b1;
        end else begin
          ad_x = r; ad_y = x;
        end
      end
      U_FIX: begin
        ad_x = '0; ad_y = fix_src; ad_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign ad_sum = {1'b0, ad_x} + {1'b0, (ad_sub ? ~ad_y : ad_y)} + {{LHC_W{1'b0}}, ad_sub};
  assign result = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ust  <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= (ust == U_ADD) || (ust == U_FIX);
      case (ust)
        U_IDLE: begin
          if (cmd.start) begin
            x   <= a;
            y   <= b;
            uop <= cmd.op;
            r   <= '0;
            cnt <= '0;
            sgn <= a[LHC_W-1] ^ b[LHC_W-1];
            ust <= (cmd.op == UOP_ADD || cmd.op == UOP_SUB) ? U_ADD : U_ABSA;
          end
        end
        U_ADD: begin
          r    <= ad_sum[LHC_W-1:0];
          ust  <= U_IDLE;
        end
        U_ABSA: begin
          if (x[LHC_W-1]) x <= ad_sum[LHC_W-1:0];
          ust <= U_ABSB;
        end
        U_ABSB: begin
          if (y[LHC_W-1]) y <= ad_sum[LHC_W-1:0];
          if (uop == UOP_DIV && y == '0) begin
            // divide by zero gives zero
            x   <= '0;
            ust <= U_FIX;
          end else begin
            ust <= U_RUN;
          end
        end
        U_RUN: begin
          if (uop == UOP_DIV) begin
            // carry out set means no borrow: divisor fits
            if (ad_sum[LHC_W]) begin
              r <= ad_sum[LHC_W-1:0];
              x <= {x[LHC_W-2:0], 1'b1};
            end else begin
              r <= rem_sh;
              x <= {x[LHC_W-2:0], 1'b0};
            end
            cnt <= cnt + 8'd1;
            if (cnt == 8'(LHC_W - 1)) ust <= U_FIX;
          end else begin
            if (y == '0) begin
              ust <= U_FIX;
            end else begin
              if (y[0]) r <= ad_sum[LHC_W-1:0];
              x <= {x[LHC_W-2:0], 1'b0};
              y <= {1'b0, y[LHC_W-1:1]};
            end
          end
        end
        U_FIX: begin
          r    <= sgn ? ad_sum[LHC_W-1:0] : fix_src;
          ust  <= U_IDLE;
        end
        default: ust <= U_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
